// ----- src/tqd_pkg.sv -----
// ----------------------------------------------------------------------------
// tqd_pkg
// shared types, request and status codes, and defaults of the two-queue
// ticket dispatcher
// ----------------------------------------------------------------------------
package tqd_pkg;

    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int NUMBER_WIDTH_DEF = 16;

    localparam int REQ_W     = 2;
    localparam int STAMP_W   = 32;
    localparam int OUT_NUM_W = 16;
    localparam int STATUS_W  = 3;
    localparam int BURST_W   = 4;

    localparam logic [BURST_W-1:0] BURST_RESET    = 4'd2;
    localparam int                 NOTHING_NUMBER = 999;

    localparam logic [REQ_W-1:0] REQ_ISSUE_NORMAL   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ISSUE_PRIORITY = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SERVE          = 2'd2;
    localparam logic [REQ_W-1:0] REQ_UNUSED         = 2'd3;

    typedef enum logic [STATUS_W-1:0] {
        ST_ISSUED     = 3'd0,
        ST_REJECTED   = 3'd1,
        ST_SERVED_PRI = 3'd2,
        ST_SERVED_NOR = 3'd3,
        ST_NOTHING    = 3'd4
    } status_t;

    // per-request control from the scheduler to the datapath
    typedef struct packed {
        logic    has_result;
        status_t status;
        logic    n_wr;
        logic    p_wr;
        logic    n_rd;
        logic    p_rd;
    } ctl_t;

endpackage

// ----- src/tqd_queue_mem.sv -----
// ----------------------------------------------------------------------------
// tqd_queue_mem
// one-write one-read synchronous ticket store, read data registered
// ----------------------------------------------------------------------------
module tqd_queue_mem #(
    parameter int DEPTH = tqd_pkg::QUEUE_DEPTH_DEF,
    parameter int WIDTH = tqd_pkg::NUMBER_WIDTH_DEF + tqd_pkg::STAMP_W
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/tqd_sched.sv -----
// ----------------------------------------------------------------------------
// tqd_sched
// queue pointers, ticket counter and burst arbitration between the queues
// ----------------------------------------------------------------------------
module tqd_sched #(
    parameter int QUEUE_DEPTH  = tqd_pkg::QUEUE_DEPTH_DEF,
    parameter int NUMBER_WIDTH = tqd_pkg::NUMBER_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [tqd_pkg::REQ_W-1:0]       req_type,
    input  logic [tqd_pkg::BURST_W-1:0]     burst_limit,
    output tqd_pkg::ctl_t                   ctl,
    output logic [NUMBER_WIDTH-1:0]         number,
    output logic [$clog2(QUEUE_DEPTH)-1:0]  n_wr_addr,
    output logic [$clog2(QUEUE_DEPTH)-1:0]  n_rd_addr,
    output logic [$clog2(QUEUE_DEPTH)-1:0]  p_wr_addr,
    output logic [$clog2(QUEUE_DEPTH)-1:0]  p_rd_addr
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    logic [IDX_W-1:0]            n_head_reg, n_head_next, n_tail_reg, n_tail_next;
    logic [IDX_W-1:0]            p_head_reg, p_head_next, p_tail_reg, p_tail_next;
    logic [CNT_W-1:0]            n_cnt_reg, n_cnt_next, p_cnt_reg, p_cnt_next;
    logic [tqd_pkg::BURST_W-1:0] burst_reg, burst_next;
    logic [NUMBER_WIDTH-1:0]     ticket_reg, ticket_next;
    logic [NUMBER_WIDTH-1:0]     ticket_inc;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] ptr);
        logic [IDX_W-1:0] res;
        res = (ptr == LAST_IDX) ? '0 : ptr + 1'b1;
        return res;
    endfunction

    assign ticket_inc = ticket_reg + 1'b1;

    always_comb
    begin
        n_head_next = n_head_reg;
        n_tail_next = n_tail_reg;
        n_cnt_next  = n_cnt_reg;
        p_head_next = p_head_reg;
        p_tail_next = p_tail_reg;
        p_cnt_next  = p_cnt_reg;
        burst_next  = burst_reg;
        ticket_next = ticket_reg;
        number      = '0;
        ctl         = '0;
        ctl.status  = tqd_pkg::ST_ISSUED;

        unique case (req_type)
            tqd_pkg::REQ_ISSUE_NORMAL:
            begin
                ctl.has_result = 1'b1;
                if (n_cnt_reg == FULL_CNT)
                begin
                    ctl.status = tqd_pkg::ST_REJECTED;
                end
                else
                begin
                    ctl.n_wr    = 1'b1;
                    number      = ticket_inc;
                    ticket_next = ticket_inc;
                    n_tail_next = wrap_inc(n_tail_reg);
                    n_cnt_next  = n_cnt_reg + 1'b1;
                end
            end
            tqd_pkg::REQ_ISSUE_PRIORITY:
            begin
                ctl.has_result = 1'b1;
                if (p_cnt_reg == FULL_CNT)
                begin
                    ctl.status = tqd_pkg::ST_REJECTED;
                end
                else
                begin
                    ctl.p_wr    = 1'b1;
                    number      = ticket_inc;
                    ticket_next = ticket_inc;
                    p_tail_next = wrap_inc(p_tail_reg);
                    p_cnt_next  = p_cnt_reg + 1'b1;
                end
            end
            tqd_pkg::REQ_SERVE:
            begin
                ctl.has_result = 1'b1;
                priority if (p_cnt_reg != '0 && burst_reg < burst_limit)
                begin
                    ctl.p_rd    = 1'b1;
                    ctl.status  = tqd_pkg::ST_SERVED_PRI;
                    burst_next  = burst_reg + 1'b1;
                    p_head_next = wrap_inc(p_head_reg);
                    p_cnt_next  = p_cnt_reg - 1'b1;
                end
                else if (n_cnt_reg != '0)
                begin
                    ctl.n_rd    = 1'b1;
                    ctl.status  = tqd_pkg::ST_SERVED_NOR;
                    burst_next  = '0;
                    n_head_next = wrap_inc(n_head_reg);
                    n_cnt_next  = n_cnt_reg - 1'b1;
                end
                else if (p_cnt_reg != '0)
                begin
                    // fallback when no normal ticket waits
                    ctl.p_rd    = 1'b1;
                    ctl.status  = tqd_pkg::ST_SERVED_PRI;
                    burst_next  = tqd_pkg::BURST_W'(1);
                    p_head_next = wrap_inc(p_head_reg);
                    p_cnt_next  = p_cnt_reg - 1'b1;
                end
                else
                begin
                    ctl.status = tqd_pkg::ST_NOTHING;
                    number     = NUMBER_WIDTH'(tqd_pkg::NOTHING_NUMBER);
                    burst_next = '0;
                end
            end
            tqd_pkg::REQ_UNUSED:
            begin
                // dropped without a result
                ctl.has_result = 1'b0;
            end
            default:
            begin
                ctl.has_result = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_head_reg <= '0;
            n_tail_reg <= '0;
            n_cnt_reg  <= '0;
            p_head_reg <= '0;
            p_tail_reg <= '0;
            p_cnt_reg  <= '0;
            burst_reg  <= '0;
            ticket_reg <= '0;
        end
        else if (accept)
        begin
            n_head_reg <= n_head_next;
            n_tail_reg <= n_tail_next;
            n_cnt_reg  <= n_cnt_next;
            p_head_reg <= p_head_next;
            p_tail_reg <= p_tail_next;
            p_cnt_reg  <= p_cnt_next;
            burst_reg  <= burst_next;
            ticket_reg <= ticket_next;
        end
    end

    assign n_wr_addr = n_tail_reg;
    assign n_rd_addr = n_head_reg;
    assign p_wr_addr = p_tail_reg;
    assign p_rd_addr = p_head_reg;

endmodule

// ----- src/two_queue_ticket_dispatcher_unit.sv -----
// ----------------------------------------------------------------------------
// two_queue_ticket_dispatcher_unit
// normal and priority ticket queues with a shared ticket counter and a
// burst-limited priority arbiter
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | req_type, stamp
//  out     | out_valid / out_ready| status, ticket_number, ticket_stamp
//  cfg     | cfg_valid / cfg_ready| cfg_data (priority burst limit)
//
//  one request per cycle while in_ready is high; its result goes through the
//  middle stage to the output register, once the queue memory read data is back
//  an unused request code is consumed with no result
//  out_ready low holds the output register; the middle stage then stalls and
//  in_ready drops until the output register frees up
//  reset empties both queues, clears the counter and burst, limit is 2
// ----------------------------------------------------------------------------
module two_queue_ticket_dispatcher_unit #(
    parameter int QUEUE_DEPTH  = tqd_pkg::QUEUE_DEPTH_DEF,
    parameter int NUMBER_WIDTH = tqd_pkg::NUMBER_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [tqd_pkg::REQ_W-1:0]       req_type,
    input  logic [tqd_pkg::STAMP_W-1:0]     stamp,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tqd_pkg::STATUS_W-1:0]    status,
    output logic [tqd_pkg::OUT_NUM_W-1:0]   ticket_number,
    output logic [tqd_pkg::STAMP_W-1:0]     ticket_stamp,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tqd_pkg::BURST_W-1:0]     cfg_data
);

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int ENTRY_W = NUMBER_WIDTH + tqd_pkg::STAMP_W;

    logic                        accept;
    tqd_pkg::ctl_t               ctl;
    logic [NUMBER_WIDTH-1:0]     sched_number;
    logic [IDX_W-1:0]            n_wr_addr, n_rd_addr, p_wr_addr, p_rd_addr;
    logic [ENTRY_W-1:0]          wr_entry, n_rd_data, p_rd_data;

    logic [tqd_pkg::BURST_W-1:0] limit_reg;

    logic                        s1_valid_reg, s1_valid_next;
    tqd_pkg::status_t            s1_status_reg;
    logic [NUMBER_WIDTH-1:0]     s1_number_reg;
    logic                        s1_rd_n_reg, s1_rd_p_reg;
    logic                        s1_move;

    logic                        out_valid_reg, out_valid_next;
    logic [tqd_pkg::STATUS_W-1:0]  status_reg;
    logic [tqd_pkg::OUT_NUM_W-1:0] number_reg;
    logic [tqd_pkg::STAMP_W-1:0]   stamp_reg;

    logic [NUMBER_WIDTH-1:0]     s1_number;
    logic [tqd_pkg::STAMP_W-1:0] s1_stamp;
    logic [31:0]                 s1_number_wide;

    // config register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= tqd_pkg::BURST_RESET;
        end
        else if (cfg_valid)
        begin
            limit_reg <= cfg_data;
        end
    end

    // handshake
    assign s1_move  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_move;
    assign accept   = in_valid && in_ready;

    tqd_sched #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_sched (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .req_type    (req_type),
        .burst_limit (limit_reg),
        .ctl         (ctl),
        .number      (sched_number),
        .n_wr_addr   (n_wr_addr),
        .n_rd_addr   (n_rd_addr),
        .p_wr_addr   (p_wr_addr),
        .p_rd_addr   (p_rd_addr)
    );

    assign wr_entry = {sched_number, stamp};

    tqd_queue_mem #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_normal_mem (
        .clk     (clk),
        .wr_en   (accept && ctl.n_wr),
        .wr_addr (n_wr_addr),
        .wr_data (wr_entry),
        .rd_en   (accept && ctl.n_rd),
        .rd_addr (n_rd_addr),
        .rd_data (n_rd_data)
    );

    tqd_queue_mem #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_priority_mem (
        .clk     (clk),
        .wr_en   (accept && ctl.p_wr),
        .wr_addr (p_wr_addr),
        .wr_data (wr_entry),
        .rd_en   (accept && ctl.p_rd),
        .rd_addr (p_rd_addr),
        .rd_data (p_rd_data)
    );

    // middle stage: waits for the memory read data
    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = ctl.has_result;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= ctl.status;
            s1_number_reg <= sched_number;
            s1_rd_n_reg   <= ctl.n_rd;
            s1_rd_p_reg   <= ctl.p_rd;
        end
    end

    always_comb
    begin
        priority if (s1_rd_n_reg)
        begin
            s1_number = n_rd_data[ENTRY_W-1 -: NUMBER_WIDTH];
            s1_stamp  = n_rd_data[tqd_pkg::STAMP_W-1:0];
        end
        else if (s1_rd_p_reg)
        begin
            s1_number = p_rd_data[ENTRY_W-1 -: NUMBER_WIDTH];
            s1_stamp  = p_rd_data[tqd_pkg::STAMP_W-1:0];
        end
        else
        begin
            s1_number = s1_number_reg;
            s1_stamp  = '0;
        end
    end

    assign s1_number_wide = 32'(s1_number);

    // output register
    always_comb
    begin
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            status_reg <= s1_status_reg;
            number_reg <= s1_number_wide[tqd_pkg::OUT_NUM_W-1:0];
            stamp_reg  <= s1_stamp;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign ticket_number = number_reg;
    assign ticket_stamp  = stamp_reg;

endmodule

// ----- src/tqd_checker.sv -----
// ----------------------------------------------------------------------------
// tqd_checker
// port-level checks on the result channel of the ticket dispatcher
// ----------------------------------------------------------------------------
module tqd_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [tqd_pkg::STATUS_W-1:0]    status,
    input logic [tqd_pkg::OUT_NUM_W-1:0]   ticket_number,
    input logic [tqd_pkg::STAMP_W-1:0]     ticket_stamp
);

    // a stalled transaction keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(ticket_number) && $stable(ticket_stamp))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == tqd_pkg::ST_ISSUED || status == tqd_pkg::ST_REJECTED
            || status == tqd_pkg::ST_SERVED_PRI || status == tqd_pkg::ST_SERVED_NOR
            || status == tqd_pkg::ST_NOTHING))
        else $error("unknown status code");

    // empty queues report the fixed number and no stamp
    a_nothing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == tqd_pkg::ST_NOTHING |->
            ticket_number == tqd_pkg::OUT_NUM_W'(tqd_pkg::NOTHING_NUMBER)
            && ticket_stamp == '0)
        else $error("nothing-waiting result malformed");

    // issue results never carry a stamp, a rejection never a number
    a_issue_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == tqd_pkg::ST_ISSUED || status == tqd_pkg::ST_REJECTED) |->
            ticket_stamp == '0
            && (status == tqd_pkg::ST_ISSUED || ticket_number == '0))
        else $error("issue result malformed");

endmodule

bind two_queue_ticket_dispatcher_unit tqd_checker u_tqd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .ticket_number (ticket_number),
    .ticket_stamp  (ticket_stamp)
);
